// File: hw/rtl/vsql_pkg.sv
// shared types, constants and register indexes of the quote ladder
package vsql_pkg;

   localparam int WINDOW_MAX      = 64;
   localparam int LEVELS_MAX      = 8;
   localparam int PRICE_FRAC_BITS = 16;

   localparam int PRICE_W  = 32 + PRICE_FRAC_BITS;
   localparam int RING_AW  = $clog2(WINDOW_MAX);
   localparam int FILL_W   = $clog2(WINDOW_MAX + 1);

   localparam int LEVEL_W  = 4;
   localparam int QTY_W    = 19;
   localparam int DEPTH_W  = 16;
   localparam int Q24_W    = 24;
   localparam int ONE_Q24  = 1 << Q24_W;

   // returns are signed q15.32
   localparam int RET_INT_W  = 15;
   localparam int RET_FRAC_W = 32;
   localparam int RET_W      = RET_INT_W + RET_FRAC_W + 1;
   localparam logic [RET_W-2:0] RET_MAX = '1;
   localparam int SUM_W      = RET_W + RING_AW;

   localparam int AD_W       = 32;
   localparam int SQ_W       = 2 * AD_W;
   localparam int VOL_W      = 24;
   localparam int GPROD_W    = 2 * VOL_W;
   localparam int GAIN_FRAC  = 16;

   localparam int DIV_NUM_W  = 64;
   localparam int STEP_W     = $clog2(DIV_NUM_W + 1);

   localparam int HS_W       = 33;
   localparam int DIST_W     = HS_W + LEVEL_W;
   localparam int FACT_W     = DIST_W + 1;
   localparam int CHUNK_W    = 16;
   localparam int CHUNKS     = (PRICE_W + CHUNK_W - 1) / CHUNK_W;
   localparam int CHUNK_CW   = $clog2(CHUNKS);
   localparam int PAD_W      = CHUNKS * CHUNK_W;
   localparam int ACC_W      = PAD_W + FACT_W + 1;
   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SPREAD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOL_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_UNIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd4;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   typedef struct packed {
      logic [23:0]        base_spread;
      logic [23:0]        vol_gain;
      logic [LEVEL_W-1:0] level_count;
      logic [DEPTH_W-1:0] depth_unit;
      logic [6:0]         window_length;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [PRICE_W-1:0]   rem_init;
      logic [DIV_NUM_W-1:0] num;
      logic [STEP_W-1:0]    steps;
      logic [PRICE_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic [PRICE_W-1:0] mid;
      logic [HS_W-1:0]    hs;
      logic [LEVEL_W-1:0] levels;
   } job_type;

endpackage

// File: hw/rtl/volatility_scaled_quote_ladder_core.sv
// top level of the volatility scaled quote ladder
//
// req_* carries one mid price word (q32.16). a word is taken when req_valid is
// high and req_stall is low. a zero price is taken and dropped without effect.
// rsp_* gives the quotes of one price, for each level a bid (unless it would be
// at or below zero) then an ask, rsp_last_quote set on the final ask.
// csr_* writes one register per cycle when csr_write_enable is high.
//
// per price the front runs one 47-step divide for the new return, two passes
// over the return memory (the returns in the window, at most 63), two 64-step
// divides for mean and variance, all in one shared serial divider, and a
// 32-step square root. the front then takes the next price; a two-word queue
// feeds the back, which forms three partial products per quote.
// when the receiver stalls, the back holds its output register, the queue
// fills and req_stall rises. reset clears history and control state and loads
// the register defaults; no clearing pass over the return memory is needed.
module volatility_scaled_quote_ladder_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [vsql_pkg::PRICE_W-1:0]    req_mid_price,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_quote_side,
   output logic [vsql_pkg::PRICE_W-1:0]    rsp_quote_price,
   output logic [vsql_pkg::QTY_W-1:0]      rsp_quote_qty,
   output logic [vsql_pkg::LEVEL_W-1:0]    rsp_quote_level,
   output logic                            rsp_last_quote,
   input  logic                            csr_write_enable,
   input  logic [vsql_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vsql_pkg::CSR_DATA_W-1:0] csr_write_data
);

   vsql_pkg::cfg_type cfg_ff;
   vsql_pkg::job_type push_data, pop_data;
   logic              push, full, pop, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_spread   <= 24'd16777;
         cfg_ff.vol_gain      <= 24'd131072;
         cfg_ff.level_count   <= 4'd3;
         cfg_ff.depth_unit    <= 16'd100;
         cfg_ff.window_length <= 7'd20;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            vsql_pkg::REG_BASE_SPREAD:   cfg_ff.base_spread   <= csr_write_data;
            vsql_pkg::REG_VOL_GAIN:      cfg_ff.vol_gain      <= csr_write_data;
            vsql_pkg::REG_LEVEL_COUNT:   cfg_ff.level_count   <= csr_write_data[3:0];
            vsql_pkg::REG_DEPTH_UNIT:    cfg_ff.depth_unit    <= csr_write_data[15:0];
            vsql_pkg::REG_WINDOW_LENGTH: cfg_ff.window_length <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   vsql_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mid_price (req_mid_price),
      .cfg           (cfg_ff),
      .push          (push),
      .job           (push_data),
      .full          (full)
   );

   vsql_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   vsql_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .empty           (empty),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_quote_side  (rsp_quote_side),
      .rsp_quote_price (rsp_quote_price),
      .rsp_quote_qty   (rsp_quote_qty),
      .rsp_quote_level (rsp_quote_level),
      .rsp_last_quote  (rsp_last_quote)
   );

endmodule

// File: hw/rtl/vsql_div.sv
// bit-serial restoring divider shared by returns, mean and variance
module vsql_div (
   input  logic                  clock,
   input  logic                  reset,
   input  vsql_pkg::div_req_type req,
   output vsql_pkg::div_rsp_type rsp
);

   logic [vsql_pkg::PRICE_W-1:0]   rem_ff, rem_in, divisor_ff;
   logic [vsql_pkg::DIV_NUM_W-1:0] num_ff, quot_ff;
   logic [vsql_pkg::STEP_W-1:0]    steps_ff;
   logic                           busy_ff, done_ff;
   logic [vsql_pkg::PRICE_W:0]     trial;
   logic                           ge;

   always_comb begin
      trial  = {rem_ff, num_ff[vsql_pkg::DIV_NUM_W-1]};
      ge     = trial >= {1'b0, divisor_ff};
      rem_in = ge ? vsql_pkg::PRICE_W'(trial - {1'b0, divisor_ff})
                  : trial[vsql_pkg::PRICE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff     <= req.rem_init;
            num_ff     <= req.num;
            quot_ff    <= '0;
            steps_ff   <= req.steps;
            divisor_ff <= req.divisor;
            busy_ff    <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            num_ff   <= {num_ff[vsql_pkg::DIV_NUM_W-2:0], 1'b0};
            quot_ff  <= {quot_ff[vsql_pkg::DIV_NUM_W-2:0], ge};
            steps_ff <= steps_ff - 1'b1;
            if (steps_ff == vsql_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// File: hw/rtl/vsql_front.sv
// front end: takes prices, keeps the return history, works out the half spread
module vsql_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [vsql_pkg::PRICE_W-1:0] req_mid_price,
   input  vsql_pkg::cfg_type            cfg,
   output logic                         push,
   output vsql_pkg::job_type            job,
   input  logic                         full
);

   typedef enum logic [3:0] {
      F_IDLE, F_RET, F_RETW, F_WIN, F_SUM, F_MEAN, F_MEANW,
      F_DEV, F_VAR, F_VARW, F_SQRT, F_GAIN, F_HS, F_PUSH
   } front_state_type;

   front_state_type state_ff;

   logic [vsql_pkg::PRICE_W-1:0] mid_ff, last_ff;
   logic [vsql_pkg::RING_AW-1:0] head_ff, m_ff, iss_ff;
   logic [vsql_pkg::FILL_W-1:0]  fill_ff;
   logic                         rdv_ff, advld_ff, prvld_ff;
   logic signed [vsql_pkg::SUM_W-1:0] sum_ff, mean_ff;
   logic [vsql_pkg::AD_W-1:0]    ad_ff;
   logic [vsql_pkg::SQ_W-1:0]    prod_ff, sq_ff;
   logic [63:0]                  v_ff, res_ff, bit_ff;
   logic [4:0]                   scnt_ff;
   logic [vsql_pkg::GPROD_W-1:0] gprod_ff;
   vsql_pkg::job_type            job_ff;

   // return history, one entry per price slot
   logic signed [vsql_pkg::RET_W-1:0] ret_ring [vsql_pkg::WINDOW_MAX];
   logic signed [vsql_pkg::RET_W-1:0] ring_rdata_ff, ring_wdata;
   logic                              ring_we;
   logic [vsql_pkg::RING_AW-1:0]      ring_raddr;

   vsql_pkg::div_req_type div_req;
   vsql_pkg::div_rsp_type div_rsp;

   logic                          neg, ovf;
   logic [vsql_pkg::PRICE_W-1:0]  diff;
   logic [vsql_pkg::RET_W-2:0]    mag;
   logic [vsql_pkg::SUM_W-1:0]    sum_abs, mean_q;
   logic signed [vsql_pkg::SUM_W:0] dev;
   logic [vsql_pkg::SUM_W:0]      dev_abs, dev_sh;
   logic [vsql_pkg::AD_W-1:0]     ad_val;
   logic [vsql_pkg::SQ_W:0]       sq_sum;
   logic [64:0]                   sq_trial;
   logic                          sq_ge;
   logic [vsql_pkg::FILL_W-1:0]   fill_next, win, n_win;
   logic [vsql_pkg::VOL_W-1:0]    vol;
   logic [vsql_pkg::LEVEL_W-1:0]  levels;

   vsql_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      neg  = mid_ff < last_ff;
      diff = neg ? last_ff - mid_ff : mid_ff - last_ff;
      ovf  = {{vsql_pkg::RET_INT_W{1'b0}}, diff} >= {last_ff, {vsql_pkg::RET_INT_W{1'b0}}};
      mag  = ovf ? vsql_pkg::RET_MAX : div_rsp.quot[vsql_pkg::RET_W-2:0];
      ring_wdata = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      ring_we    = (state_ff == F_RET && fill_ff != '0 && ovf) ||
                   (state_ff == F_RETW && div_rsp.done);
      ring_raddr = head_ff - vsql_pkg::RING_AW'(1) - iss_ff;

      sum_abs = sum_ff[vsql_pkg::SUM_W-1] ? vsql_pkg::SUM_W'(-sum_ff)
                                          : vsql_pkg::SUM_W'(sum_ff);
      mean_q  = div_rsp.quot[vsql_pkg::SUM_W-1:0];

      dev = {{(vsql_pkg::SUM_W+1-vsql_pkg::RET_W){ring_rdata_ff[vsql_pkg::RET_W-1]}},
             ring_rdata_ff} - {mean_ff[vsql_pkg::SUM_W-1], mean_ff};
      dev_abs = dev[vsql_pkg::SUM_W] ? (vsql_pkg::SUM_W+1)'(-dev) : (vsql_pkg::SUM_W+1)'(dev);
      dev_sh  = dev_abs >> 8;
      ad_val  = (dev_sh > (vsql_pkg::SUM_W+1)'(64'd1 << 31)) ? vsql_pkg::AD_W'(64'd1 << 31)
                                                          : dev_sh[vsql_pkg::AD_W-1:0];
      sq_sum  = {1'b0, sq_ff} + {1'b0, prod_ff};

      sq_trial = {1'b0, res_ff} + {1'b0, bit_ff};
      sq_ge    = {1'b0, v_ff} >= sq_trial;

      fill_next = (fill_ff == vsql_pkg::FILL_W'(vsql_pkg::WINDOW_MAX)) ? fill_ff
                                                                   : fill_ff + 1'b1;
      if (cfg.window_length < 7'd2)
         win = vsql_pkg::FILL_W'(2);
      else if ({25'b0, cfg.window_length} > vsql_pkg::WINDOW_MAX)
         win = vsql_pkg::FILL_W'(vsql_pkg::WINDOW_MAX);
      else
         win = vsql_pkg::FILL_W'(cfg.window_length);
      n_win = (fill_next < win) ? fill_next : win;

      vol = (res_ff > 64'(24'hFFFFFF)) ? 24'hFFFFFF : res_ff[vsql_pkg::VOL_W-1:0];
      levels = ({28'b0, cfg.level_count} > vsql_pkg::LEVELS_MAX)
             ? vsql_pkg::LEVEL_W'(vsql_pkg::LEVELS_MAX) : cfg.level_count;

      div_req.start    = 1'b0;
      div_req.rem_init = diff >> vsql_pkg::RET_INT_W;
      div_req.num      = {diff[vsql_pkg::RET_INT_W-1:0],
                          {(vsql_pkg::DIV_NUM_W-vsql_pkg::RET_INT_W){1'b0}}};
      div_req.steps    = vsql_pkg::STEP_W'(vsql_pkg::RET_W - 1);
      div_req.divisor  = last_ff;
      unique case (state_ff)
         F_RET: begin
            div_req.start = (fill_ff != '0) && !ovf;
         end
         F_MEAN: begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.num      = vsql_pkg::DIV_NUM_W'(sum_abs);
            div_req.steps    = vsql_pkg::STEP_W'(vsql_pkg::DIV_NUM_W);
            div_req.divisor  = vsql_pkg::PRICE_W'(m_ff);
         end
         F_VAR: begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.num      = sq_ff;
            div_req.steps    = vsql_pkg::STEP_W'(vsql_pkg::DIV_NUM_W);
            div_req.divisor  = vsql_pkg::PRICE_W'(m_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we)
         ret_ring[head_ff] <= ring_wdata;
      ring_rdata_ff <= ret_ring[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         rdv_ff   <= 1'b0;
         advld_ff <= 1'b0;
         prvld_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid && req_mid_price != '0) begin
                  mid_ff   <= req_mid_price;
                  state_ff <= F_RET;
               end
            end
            F_RET: begin
               if (fill_ff == '0 || ovf)
                  state_ff <= F_WIN;
               else
                  state_ff <= F_RETW;
            end
            F_RETW: begin
               if (div_rsp.done)
                  state_ff <= F_WIN;
            end
            F_WIN: begin
               head_ff <= head_ff + 1'b1;
               fill_ff <= fill_next;
               last_ff <= mid_ff;
               iss_ff  <= '0;
               rdv_ff  <= 1'b0;
               sum_ff  <= '0;
               m_ff    <= vsql_pkg::RING_AW'(n_win - 1'b1);
               if (n_win < vsql_pkg::FILL_W'(2)) begin
                  res_ff   <= '0;
                  state_ff <= F_GAIN;
               end else begin
                  state_ff <= F_SUM;
               end
            end
            F_SUM: begin
               rdv_ff <= (iss_ff != m_ff);
               if (iss_ff != m_ff)
                  iss_ff <= iss_ff + 1'b1;
               if (rdv_ff)
                  sum_ff <= sum_ff + {{(vsql_pkg::SUM_W-vsql_pkg::RET_W){
                            ring_rdata_ff[vsql_pkg::RET_W-1]}}, ring_rdata_ff};
               if (iss_ff == m_ff && !rdv_ff)
                  state_ff <= F_MEAN;
            end
            F_MEAN: begin
               state_ff <= F_MEANW;
            end
            F_MEANW: begin
               if (div_rsp.done) begin
                  mean_ff  <= sum_ff[vsql_pkg::SUM_W-1] ? -$signed(mean_q) : $signed(mean_q);
                  iss_ff   <= '0;
                  rdv_ff   <= 1'b0;
                  advld_ff <= 1'b0;
                  prvld_ff <= 1'b0;
                  sq_ff    <= '0;
                  state_ff <= F_DEV;
               end
            end
            F_DEV: begin
               // read, deviation, square, saturating sum
               rdv_ff <= (iss_ff != m_ff);
               if (iss_ff != m_ff)
                  iss_ff <= iss_ff + 1'b1;
               advld_ff <= rdv_ff;
               ad_ff    <= ad_val;
               prvld_ff <= advld_ff;
               prod_ff  <= vsql_pkg::SQ_W'(ad_ff) * vsql_pkg::SQ_W'(ad_ff);
               if (prvld_ff)
                  sq_ff <= sq_sum[vsql_pkg::SQ_W] ? '1 : sq_sum[vsql_pkg::SQ_W-1:0];
               if (iss_ff == m_ff && !rdv_ff && !advld_ff && !prvld_ff)
                  state_ff <= F_VAR;
            end
            F_VAR: begin
               state_ff <= F_VARW;
            end
            F_VARW: begin
               if (div_rsp.done) begin
                  v_ff     <= div_rsp.quot;
                  res_ff   <= '0;
                  bit_ff   <= 64'd1 << 62;
                  scnt_ff  <= '0;
                  state_ff <= F_SQRT;
               end
            end
            F_SQRT: begin
               if (sq_ge) begin
                  v_ff   <= v_ff - sq_trial[63:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               scnt_ff <= scnt_ff + 1'b1;
               if (scnt_ff == 5'd31)
                  state_ff <= F_GAIN;
            end
            F_GAIN: begin
               gprod_ff <= {24'b0, vol} * {24'b0, cfg.vol_gain};
               state_ff <= F_HS;
            end
            F_HS: begin
               job_ff.mid    <= mid_ff;
               job_ff.hs     <= vsql_pkg::HS_W'(cfg.base_spread) +
                                vsql_pkg::HS_W'(gprod_ff >> vsql_pkg::GAIN_FRAC);
               job_ff.levels <= levels;
               state_ff      <= (levels == '0) ? F_IDLE : F_PUSH;
            end
            F_PUSH: begin
               if (!full)
                  state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PUSH) && !full;
   assign job       = job_ff;

endmodule

// File: hw/rtl/vsql_fifo.sv
// two-entry job queue between front and back
module vsql_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vsql_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output vsql_pkg::job_type pop_data,
   output logic              empty
);

   vsql_pkg::job_type entry_ff [2];
   logic              wp_ff, rp_ff;
   logic [1:0]        cnt_ff;

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push)
            wp_ff <= ~wp_ff;
         if (pop)
            rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = entry_ff[rp_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("job queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("job queue read while empty");

endmodule

// File: hw/rtl/vsql_back.sv
// back end: walks the levels and prices each bid and ask
module vsql_back (
   input  logic                         clock,
   input  logic                         reset,
   input  vsql_pkg::cfg_type            cfg,
   input  logic                         empty,
   input  vsql_pkg::job_type            pop_data,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_quote_side,
   output logic [vsql_pkg::PRICE_W-1:0] rsp_quote_price,
   output logic [vsql_pkg::QTY_W-1:0]   rsp_quote_qty,
   output logic [vsql_pkg::LEVEL_W-1:0] rsp_quote_level,
   output logic                         rsp_last_quote
);

   typedef enum logic [1:0] {B_IDLE, B_SETUP, B_MUL, B_OUT} back_state_type;

   back_state_type state_ff;

   logic [vsql_pkg::PRICE_W-1:0]  mid_ff;
   logic [vsql_pkg::HS_W-1:0]     hs_ff;
   logic [vsql_pkg::LEVEL_W-1:0]  levels_ff, lv_ff;
   logic [vsql_pkg::DIST_W-1:0]   dist_ff;
   logic [vsql_pkg::QTY_W-1:0]    qty_ff;
   logic                          side_ff;
   logic [vsql_pkg::ACC_W-1:0]    acc_ff;
   logic [vsql_pkg::CHUNK_CW-1:0] chunk_ff;

   logic                          rsp_valid_ff, rsp_side_ff, rsp_last_ff;
   logic [vsql_pkg::PRICE_W-1:0]  rsp_price_ff;
   logic [vsql_pkg::QTY_W-1:0]    rsp_qty_ff;
   logic [vsql_pkg::LEVEL_W-1:0]  rsp_level_ff;
   logic                          rsp_valid_in;

   logic [vsql_pkg::PAD_W-1:0]    mid_pad;
   logic [vsql_pkg::CHUNK_W-1:0]  chunk_val;
   logic [vsql_pkg::FACT_W-1:0]   fac;
   logic [vsql_pkg::CHUNK_W+vsql_pkg::FACT_W-1:0] part;
   logic [vsql_pkg::ACC_W-1:0]    rnd;
   logic [vsql_pkg::PRICE_W-1:0]  price;
   logic                          out_free, bid_far, drop, last;

   always_comb begin
      mid_pad   = vsql_pkg::PAD_W'(mid_ff);
      chunk_val = mid_pad[chunk_ff*vsql_pkg::CHUNK_W +: vsql_pkg::CHUNK_W];
      fac = (side_ff == vsql_pkg::SIDE_ASK)
          ? vsql_pkg::FACT_W'(vsql_pkg::ONE_Q24) + vsql_pkg::FACT_W'(dist_ff)
          : vsql_pkg::FACT_W'(vsql_pkg::ONE_Q24) - vsql_pkg::FACT_W'(dist_ff);
      part = {{vsql_pkg::FACT_W{1'b0}}, chunk_val} * {{vsql_pkg::CHUNK_W{1'b0}}, fac};
      // round half up to the price lsb, then saturate
      rnd   = (acc_ff + vsql_pkg::ACC_W'(1 << (vsql_pkg::Q24_W - 1))) >> vsql_pkg::Q24_W;
      price = (rnd > {{(vsql_pkg::ACC_W-vsql_pkg::PRICE_W){1'b0}}, vsql_pkg::PRICE_MAX})
            ? vsql_pkg::PRICE_MAX : rnd[vsql_pkg::PRICE_W-1:0];
      bid_far  = |dist_ff[vsql_pkg::DIST_W-1:vsql_pkg::Q24_W];
      drop     = (side_ff == vsql_pkg::SIDE_BID) && (price == '0);
      last     = (side_ff == vsql_pkg::SIDE_ASK) && (lv_ff == levels_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = ((state_ff == B_OUT) && !drop && out_free) ||
                     (rsp_valid_ff && rsp_stall);
   end

   assign pop = (state_ff == B_IDLE) && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  mid_ff    <= pop_data.mid;
                  hs_ff     <= pop_data.hs;
                  levels_ff <= pop_data.levels;
                  dist_ff   <= vsql_pkg::DIST_W'(pop_data.hs);
                  qty_ff    <= vsql_pkg::QTY_W'(cfg.depth_unit);
                  lv_ff     <= vsql_pkg::LEVEL_W'(1);
                  side_ff   <= vsql_pkg::SIDE_BID;
                  state_ff  <= B_SETUP;
               end
            end
            B_SETUP: begin
               if (side_ff == vsql_pkg::SIDE_BID && bid_far) begin
                  side_ff <= vsql_pkg::SIDE_ASK;
               end else begin
                  acc_ff   <= '0;
                  chunk_ff <= '0;
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               acc_ff   <= acc_ff + (vsql_pkg::ACC_W'(part) << (chunk_ff * vsql_pkg::CHUNK_W));
               chunk_ff <= chunk_ff + 1'b1;
               if (chunk_ff == vsql_pkg::CHUNK_CW'(vsql_pkg::CHUNKS - 1))
                  state_ff <= B_OUT;
            end
            B_OUT: begin
               if (drop || out_free) begin
                  if (!drop) begin
                     rsp_side_ff  <= side_ff;
                     rsp_price_ff <= price;
                     rsp_qty_ff   <= qty_ff;
                     rsp_level_ff <= lv_ff;
                     rsp_last_ff  <= last;
                  end
                  if (side_ff == vsql_pkg::SIDE_BID) begin
                     side_ff  <= vsql_pkg::SIDE_ASK;
                     state_ff <= B_SETUP;
                  end else if (last) begin
                     state_ff <= B_IDLE;
                  end else begin
                     lv_ff    <= lv_ff + 1'b1;
                     dist_ff  <= dist_ff + vsql_pkg::DIST_W'(hs_ff);
                     qty_ff   <= qty_ff + vsql_pkg::QTY_W'(cfg.depth_unit);
                     side_ff  <= vsql_pkg::SIDE_BID;
                     state_ff <= B_SETUP;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quote_side  = rsp_side_ff;
   assign rsp_quote_price = rsp_price_ff;
   assign rsp_quote_qty   = rsp_qty_ff;
   assign rsp_quote_level = rsp_level_ff;
   assign rsp_last_quote  = rsp_last_ff;

   a_last_is_ask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_side_ff == vsql_pkg::SIDE_ASK)
      else $error("last word of a ladder is not an ask");
   a_level_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff != '0)
      else $error("quote with level zero");

endmodule

// File: tb/volatility_scaled_quote_ladder_core_tb.sv
// self-checking testbench of the volatility scaled quote ladder core
`timescale 1ns / 1ps

module volatility_scaled_quote_ladder_core_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 700;

   typedef struct packed {
      logic                         side;
      logic [vsql_pkg::PRICE_W-1:0] price;
      logic [vsql_pkg::QTY_W-1:0]   qty;
      logic [vsql_pkg::LEVEL_W-1:0] level;
      logic                         last;
   } quote_type;

   class quote_board;
      logic [vsql_pkg::PRICE_W-1:0] ring[vsql_pkg::WINDOW_MAX];
      int                 head;
      int                 fill;
      vsql_pkg::cfg_type  cfg;
      quote_type          quotes_due[$];
      int                 errors;

      function void clear();
         head = 0;
         fill = 0;
         cfg.base_spread   = 24'd16777;
         cfg.vol_gain      = 24'd131072;
         cfg.level_count   = 4'd3;
         cfg.depth_unit    = 16'd100;
         cfg.window_length = 7'd20;
         errors = 0;
      endfunction

      function void set_reg(logic [vsql_pkg::CSR_IDX_W-1:0] idx,
                            logic [vsql_pkg::CSR_DATA_W-1:0] v);
         case (idx)
            vsql_pkg::REG_BASE_SPREAD:   cfg.base_spread   = v;
            vsql_pkg::REG_VOL_GAIN:      cfg.vol_gain      = v;
            vsql_pkg::REG_LEVEL_COUNT:   cfg.level_count   = v[vsql_pkg::LEVEL_W-1:0];
            vsql_pkg::REG_DEPTH_UNIT:    cfg.depth_unit    = v[vsql_pkg::DEPTH_W-1:0];
            vsql_pkg::REG_WINDOW_LENGTH: cfg.window_length = v[6:0];
            default: ;
         endcase
      endfunction

      // signed q15.32 return, magnitude truncated
      function longint ret_of(longint unsigned cur, longint unsigned prev);
         longint unsigned diff, q0, rem, mag;
         bit neg;
         neg  = cur < prev;
         diff = neg ? prev - cur : cur - prev;
         q0   = diff / prev;
         rem  = diff % prev;
         if (q0 >= 64'd32768) mag = (64'd1 << 47) - 1;
         else begin
            mag = q0;
            for (int b = 0; b < 32; b++) begin
               mag = mag << 1;
               if (rem >= prev - rem) begin
                  rem = rem - (prev - rem);
                  mag = mag | 64'd1;
               end else begin
                  rem = rem << 1;
               end
            end
         end
         return neg ? -longint'(mag) : longint'(mag);
      endfunction

      function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint unsigned vol_of_window();
         int             win, n, m, idx0, idx1;
         longint         rets[vsql_pkg::WINDOW_MAX];
         longint         sum, mean, d;
         longint unsigned sq, ad, s, vol;
         win = cfg.window_length;
         if (win < 2) win = 2;
         if (win > vsql_pkg::WINDOW_MAX) win = vsql_pkg::WINDOW_MAX;
         n = fill < win ? fill : win;
         if (n < 2) return 0;
         m   = n - 1;
         sum = 0;
         for (int k = 0; k < m; k++) begin
            idx0 = (head + vsql_pkg::WINDOW_MAX - n + k) % vsql_pkg::WINDOW_MAX;
            idx1 = (head + vsql_pkg::WINDOW_MAX - n + k + 1) % vsql_pkg::WINDOW_MAX;
            rets[k] = ret_of(ring[idx1], ring[idx0]);
            sum += rets[k];
         end
         mean = sum / m;
         sq   = 0;
         for (int k = 0; k < m; k++) begin
            d  = rets[k] - mean;
            ad = d < 0 ? longint'(-d) : longint'(d);
            ad = ad >> 8;
            if (ad > (64'd1 << 31)) ad = 64'd1 << 31;
            s  = ad * ad;
            sq = (sq > ~64'd0 - s) ? ~64'd0 : sq + s;
         end
         vol = floor_sqrt(sq / m);
         return vol > 64'hFF_FFFF ? 64'hFF_FFFF : vol;
      endfunction

      // price times q.24 factor, rounded half up, saturated
      function logic [vsql_pkg::PRICE_W-1:0] scale(longint unsigned p, longint unsigned f);
         longint unsigned hi, lo, a, b, pmax;
         pmax = 64'(vsql_pkg::PRICE_MAX);
         hi = p >> 24;
         lo = p & 64'hFF_FFFF;
         if (f != 0 && hi > pmax / f) return vsql_pkg::PRICE_MAX;
         a = hi * f;
         b = (lo * f + 64'h80_0000) >> 24;
         if (a > pmax - b) return vsql_pkg::PRICE_MAX;
         return vsql_pkg::PRICE_W'(a + b);
      endfunction

      function void note_price(logic [vsql_pkg::PRICE_W-1:0] mid);
         longint unsigned vol, hs, gap, one, nlev;
         logic [vsql_pkg::PRICE_W-1:0] bid;
         quote_type q;
         int first;
         if (mid == 0) return;
         ring[head] = mid;
         head = (head + 1) % vsql_pkg::WINDOW_MAX;
         if (fill < vsql_pkg::WINDOW_MAX) fill++;
         vol  = vol_of_window();
         hs   = cfg.base_spread + ((vol * cfg.vol_gain) >> 16);
         nlev = cfg.level_count > vsql_pkg::LEVELS_MAX ? vsql_pkg::LEVELS_MAX
                                                       : cfg.level_count;
         one  = 64'd1 << 24;
         first = quotes_due.size();
         for (longint unsigned lv = 1; lv <= nlev; lv++) begin
            gap      = hs * lv;
            q.qty    = vsql_pkg::QTY_W'(cfg.depth_unit * lv);
            q.level  = vsql_pkg::LEVEL_W'(lv);
            q.last   = 1'b0;
            if (gap < one) begin
               bid = scale(mid, one - gap);
               if (bid != 0) begin
                  q.side  = vsql_pkg::SIDE_BID;
                  q.price = bid;
                  quotes_due.insert(quotes_due.size(), q);
               end
            end
            q.side  = vsql_pkg::SIDE_ASK;
            q.price = scale(mid, one + gap);
            quotes_due.insert(quotes_due.size(), q);
         end
         if (quotes_due.size() > first) quotes_due[$].last = 1'b1;
      endfunction

      function void check(quote_type got);
         quote_type want;
         if (quotes_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected quote: side %0d price %h qty %0d level %0d last %0d",
                        got.side, got.price, got.qty, got.level, got.last);
            return;
         end
         want = quotes_due[0];
         quotes_due.delete(0);
         if (want != got) begin
            errors++;
            if (errors <= 10)
               $display("quote mismatch: exp side %0d price %h qty %0d lvl %0d last %0d, ",
                        want.side, want.price, want.qty, want.level, want.last,
                        "got side %0d price %h qty %0d lvl %0d last %0d",
                        got.side, got.price, got.qty, got.level, got.last);
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [vsql_pkg::PRICE_W-1:0]    req_mid_price = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_quote_side;
   logic [vsql_pkg::PRICE_W-1:0]    rsp_quote_price;
   logic [vsql_pkg::QTY_W-1:0]      rsp_quote_qty;
   logic [vsql_pkg::LEVEL_W-1:0]    rsp_quote_level;
   logic                            rsp_last_quote;
   logic                            csr_write_enable = 1'b0;
   logic [vsql_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [vsql_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   quote_board board = new();
   int send_idle_pct  = 0;
   int rx_stall_pct   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   logic [vsql_pkg::PRICE_W-1:0] walk_price = 48'h64_0000;

   volatility_scaled_quote_ladder_core u_dut (.*);

   always #1 clock = ~clock;

   // receiver stall, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_valid && !rsp_stall)
            board.check('{rsp_quote_side, rsp_quote_price, rsp_quote_qty,
                          rsp_quote_level, rsp_last_quote});
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_word(logic [vsql_pkg::PRICE_W-1:0] mid);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_mid_price = mid;
      do @(posedge clock); while (req_stall);
      board.note_price(mid);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.quotes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [vsql_pkg::CSR_IDX_W-1:0] idx,
                            logic [vsql_pkg::CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = v;
      board.set_reg(idx, v);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic load_cfg(logic [23:0] bs, logic [23:0] g, logic [23:0] lc,
                           logic [23:0] du, logic [23:0] wl);
      write_reg(vsql_pkg::REG_BASE_SPREAD, bs);
      write_reg(vsql_pkg::REG_VOL_GAIN, g);
      write_reg(vsql_pkg::REG_LEVEL_COUNT, lc);
      write_reg(vsql_pkg::REG_DEPTH_UNIT, du);
      write_reg(vsql_pkg::REG_WINDOW_LENGTH, wl);
   endtask

   // mostly a random walk so the window sees realistic returns
   function automatic logic [vsql_pkg::PRICE_W-1:0] next_price();
      logic [vsql_pkg::PRICE_W-1:0] step;
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 18) return vsql_pkg::PRICE_W'({$urandom, $urandom});
      if (pick < 22)
         walk_price = vsql_pkg::PRICE_W'(({$urandom, $urandom} >> $urandom_range(16, 63))
                                         | 64'd1);
      step = walk_price >> $urandom_range(3, 14);
      if ($urandom_range(1)) walk_price = walk_price + step;
      else walk_price = walk_price - step;
      if (walk_price == 0) walk_price = 48'h1_0000;
      return walk_price;
   endfunction

   task automatic random_phase(int n, int idle_pct, int stall_pct, bit pressure);
      send_idle_pct = idle_pct;
      rx_stall_pct  = stall_pct;
      if (pressure) hold_left = 3000;
      for (int i = 0; i < n; i++) send_word(next_price());
      settle();
   endtask

   initial begin
      board.clear();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: defaults, extreme prices, history growing
      send_word('0);
      send_word(48'd1);
      send_word(vsql_pkg::PRICE_MAX);
      send_word(48'h8000_0000_0000);
      send_word(48'h1_0000);
      send_word(48'h1_0001);
      send_word(48'h0_FFFF);
      settle();
      // largest settings: clamped levels and window, asks saturate, bids dropped
      load_cfg(24'hFF_FFFF, 24'hFF_FFFF, 24'd15, 24'hFF_FFFF, 24'd127);
      send_word(vsql_pkg::PRICE_MAX);
      send_word(48'd1);
      send_word(48'h5555_5555_5555);
      send_word(48'hAAAA_AAAA_AAAA);
      settle();
      // zero levels still update history; zero depth; window below two
      load_cfg(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      send_word(48'h10_0000);
      send_word(48'h20_0000);
      settle();
      write_reg(vsql_pkg::REG_LEVEL_COUNT, 24'd8);
      write_reg(vsql_pkg::REG_WINDOW_LENGTH, 24'd1);
      send_word(48'h30_0000);
      send_word(48'd3);
      settle();
      // bid distance just under and at one
      load_cfg(24'h7F_FFFF, 24'd0, 24'd2, 24'd1, 24'd2);
      send_word(48'h1234_5678_9ABC);
      settle();
      write_reg(vsql_pkg::REG_BASE_SPREAD, 24'h80_0000);
      send_word(48'h1234_5678_9ABC);
      settle();

      load_cfg(24'd16777, 24'd131072, 24'd8, 24'd100, 24'd64);
      random_phase(45, 0, 0, 1'b0);
      load_cfg(24'h00_4000, 24'h10_0000, 24'd3, 24'd65535, 24'd5);
      random_phase(45, 58, 0, 1'b0);
      load_cfg(24'd100, 24'h40_0000, 24'd8, 24'd7, 24'd20);
      random_phase(45, 0, 58, 1'b1);
      load_cfg(24'h01_0000, 24'd65536, 24'd1, 24'd1, 24'd2);
      random_phase(45, 35, 35, 1'b0);
      load_cfg(24'd16777, 24'd131072, 24'd4, 24'd300, 24'd64);
      random_phase(40, 0, 0, 1'b0);

      if (board.quotes_due.size() != 0) board.errors++;
      if (board.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/vsql_pkg.sv
hw/rtl/vsql_div.sv
hw/rtl/vsql_front.sv
hw/rtl/vsql_fifo.sv
hw/rtl/vsql_back.sv
hw/rtl/volatility_scaled_quote_ladder_core.sv
tb/volatility_scaled_quote_ladder_core_tb.sv
